// ===== hw/rtl/btc_pkg.sv =====
`timescale 1ns / 1ps

package btc_pkg;

    // Internal fixed-point format: signed 64-bit words with this many fraction bits.
    localparam int INTERNAL_FRAC_BITS = 24;
    localparam int SH_W = 6;

    localparam logic signed [63:0] ONE_F     = 64'sd1 <<< INTERNAL_FRAC_BITS;
    localparam logic signed [63:0] V_OFFSET  = 64'sd64000 <<< INTERNAL_FRAC_BITS;
    localparam logic signed [63:0] P4_SCALE  = 64'sd1 <<< (16 + INTERNAL_FRAC_BITS);
    localparam logic signed [63:0] DIV_MUL   = 64'sd6250;
    localparam logic signed [63:0] PRESS_MAX = 64'sd67108863;
    localparam logic signed [63:0] UNIT_ONE  = 64'sd1;
    localparam logic [63:0]        TEMP_DEN  = 64'd5120 << 14;
    localparam logic [20:0]        ADC_FULL  = 21'd1048576;
    localparam int                 V_SHIFT   = INTERNAL_FRAC_BITS - 11;

    // Rounding shifts applied after each product.
    localparam logic [SH_W-1:0] SH_NONE = SH_W'(0);
    localparam logic [SH_W-1:0] SH_FRAC = SH_W'(INTERNAL_FRAC_BITS);
    localparam logic [SH_W-1:0] SH_2    = SH_W'(2);
    localparam logic [SH_W-1:0] SH_4    = SH_W'(4);
    localparam logic [SH_W-1:0] SH_12   = SH_W'(12);
    localparam logic [SH_W-1:0] SH_15   = SH_W'(15);
    localparam logic [SH_W-1:0] SH_19   = SH_W'(19);
    localparam logic [SH_W-1:0] SH_31   = SH_W'(31);
    localparam logic [SH_W-1:0] SH_OUT  = SH_W'(INTERNAL_FRAC_BITS - 8);

    // Configuration register indexes.
    localparam logic [1:0] CFG_TEMP_TRIM = 2'd0;
    localparam logic [1:0] CFG_PRES_A    = 2'd1;
    localparam logic [1:0] CFG_PRES_B    = 2'd2;
    localparam logic [1:0] CFG_PRES_C    = 2'd3;

    // Command codes.
    localparam logic [1:0] CMD_BOTH  = 2'd0;
    localparam logic [1:0] CMD_TEMP  = 2'd1;
    localparam logic [1:0] CMD_PRESS = 2'd2;

    typedef struct packed {
        logic                    start;
        logic signed [63:0]      a;
        logic signed [63:0]      b;
        logic [SH_W-1:0]         sh;
    } mul_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [63:0]      res;
        logic [127:0]            prod;
    } mul_rsp_t;

    typedef struct packed {
        logic                    start;
        logic [127:0]            dividend;
        logic [63:0]             divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic [127:0]            quo;
        logic [127:0]            quo_rnd;
    } div_rsp_t;

    typedef struct packed {
        logic                    ready;
        logic                    done;
    } core_stat_t;

    // Magnitude of a signed word; the most negative value maps to 2^63.
    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (64'd0 - 64'(v)) : 64'(v);
    endfunction

    // Saturating signed add.
    function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    // Apply a sign to a 128-bit magnitude and saturate to the signed 64-bit range.
    function automatic logic signed [63:0] signsat(input logic neg,
                                                   input logic [127:0] m);
        if (|m[127:63])
            return neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return neg ? (64'd0 - m[63:0]) : m[63:0];
    endfunction

endpackage

// ===== hw/rtl/btc_mul.sv =====
`timescale 1ns / 1ps

module btc_mul
(
    input  logic              clk,
    input  logic              rst_n,
    input  btc_pkg::mul_req_t req,
    output btc_pkg::mul_rsp_t rsp
);
    import btc_pkg::*;

    localparam logic [2:0] CNT_ROUND = 3'd4;
    localparam logic [2:0] CNT_SAT   = 3'd5;

    logic               busy_reg;
    logic [2:0]         cnt_reg;
    logic               done_reg;
    logic [63:0]        ma_reg;
    logic [63:0]        mb_reg;
    logic               neg_reg;
    logic [SH_W-1:0]    sh_reg;
    logic [127:0]       acc_reg;
    logic [127:0]       rnd_reg;
    logic signed [63:0] res_reg;

    logic [31:0]        op_a;
    logic [31:0]        op_b;
    logic [63:0]        pp;
    logic [127:0]       pp_sh;
    logic [127:0]       half;
    logic [127:0]       rounded;

    // One 32x32 partial product a cycle, placed by the half-word indexes.
    always_comb
    begin
        op_a = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        op_b = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        pp   = op_a * op_b;
        unique case (cnt_reg[1:0])
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    // Round to nearest, ties away from zero, on the magnitude.
    always_comb
    begin
        half    = (sh_reg == SH_NONE) ? 128'd0 : (128'd1 << (sh_reg - SH_W'(1)));
        rounded = (acc_reg + half) >> sh_reg;
    end

    // Sequence control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_SAT);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == CNT_SAT)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Operands, accumulator and result.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ma_reg  <= mag64(req.a);
            mb_reg  <= mag64(req.b);
            neg_reg <= req.a[63] ^ req.b[63];
            sh_reg  <= req.sh;
            acc_reg <= 128'd0;
        end
        else if (busy_reg)
        begin
            unique case (cnt_reg)
                3'd0, 3'd1, 3'd2, 3'd3: acc_reg <= acc_reg + pp_sh;
                CNT_ROUND:              rnd_reg <= rounded;
                CNT_SAT:                res_reg <= signsat(neg_reg, rnd_reg);
                default:                ;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;
    assign rsp.prod = acc_reg;

endmodule

// ===== hw/rtl/btc_div.sv =====
`timescale 1ns / 1ps

module btc_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  btc_pkg::div_req_t req,
    output btc_pkg::div_rsp_t rsp
);
    import btc_pkg::*;

    logic         busy_reg;
    logic         fin_reg;
    logic         done_reg;
    logic [6:0]   cnt_reg;
    logic [127:0] dq_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  d_reg;
    logic [127:0] quo_rnd_reg;

    logic [63:0]  cand;
    logic         ge;
    logic [63:0]  rem_sub;
    logic         rnd;

    // One restoring step: the remainder stays below the divisor, so 64 bits hold it.
    always_comb
    begin
        cand    = {rem_reg[62:0], dq_reg[127]};
        ge      = cand >= d_reg;
        rem_sub = ge ? (cand - d_reg) : cand;
        rnd     = rem_reg >= (d_reg - rem_reg);
    end

    // Step counter and completion.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= busy_reg && fin_reg;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                fin_reg  <= 1'b0;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg)
            begin
                if (fin_reg)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (&cnt_reg)
                        fin_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient shifts in where the dividend shifts out.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dq_reg  <= req.dividend;
            rem_reg <= 64'd0;
            d_reg   <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (fin_reg)
                quo_rnd_reg <= dq_reg + {127'd0, rnd};
            else
            begin
                dq_reg  <= {dq_reg[126:0], ge};
                rem_reg <= rem_sub;
            end
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.quo     = dq_reg;
    assign rsp.quo_rnd = quo_rnd_reg;

endmodule

// ===== hw/rtl/btc_core.sv =====
`timescale 1ns / 1ps

module btc_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          command,
    input  logic [19:0]         raw_temp,
    input  logic [19:0]         raw_press,
    input  logic                take,
    input  logic [47:0]         temp_trim,
    input  logic [63:0]         pres_trim_a,
    input  logic [63:0]         pres_trim_b,
    input  logic [15:0]         pres_trim_c,
    output btc_pkg::core_stat_t stat,
    output logic [23:0]         temp_res,
    output logic [25:0]         press_res,
    output logic                ok_res,
    output btc_pkg::mul_req_t   mul_req,
    input  btc_pkg::mul_rsp_t   mul_rsp,
    output btc_pkg::div_req_t   div_req,
    input  btc_pkg::div_rsp_t   div_rsp
);
    import btc_pkg::*;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_T_MUL1 = 5'd1;
    localparam logic [4:0] ST_T_MUL2 = 5'd2;
    localparam logic [4:0] ST_T_MUL3 = 5'd3;
    localparam logic [4:0] ST_T_ADD  = 5'd4;
    localparam logic [4:0] ST_T_DIV  = 5'd5;
    localparam logic [4:0] ST_P_V    = 5'd6;
    localparam logic [4:0] ST_P_SQ   = 5'd7;
    localparam logic [4:0] ST_P_A1   = 5'd8;
    localparam logic [4:0] ST_P_A2   = 5'd9;
    localparam logic [4:0] ST_P_A3   = 5'd10;
    localparam logic [4:0] ST_P_A4   = 5'd11;
    localparam logic [4:0] ST_P_B1   = 5'd12;
    localparam logic [4:0] ST_P_B2   = 5'd13;
    localparam logic [4:0] ST_P_B3   = 5'd14;
    localparam logic [4:0] ST_P_B4   = 5'd15;
    localparam logic [4:0] ST_P_B5   = 5'd16;
    localparam logic [4:0] ST_P_P1   = 5'd17;
    localparam logic [4:0] ST_P_P2M  = 5'd18;
    localparam logic [4:0] ST_P_P2D  = 5'd19;
    localparam logic [4:0] ST_P_X1   = 5'd20;
    localparam logic [4:0] ST_P_X2   = 5'd21;
    localparam logic [4:0] ST_P_Y    = 5'd22;
    localparam logic [4:0] ST_P_S1   = 5'd23;
    localparam logic [4:0] ST_P_S2   = 5'd24;
    localparam logic [4:0] ST_P_S3   = 5'd25;
    localparam logic [4:0] ST_P_Q    = 5'd26;
    localparam logic [4:0] ST_DONE   = 5'd27;

    logic [4:0]         state_reg, state_next;
    logic               issued_reg, issued_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic [19:0]        raw_temp_reg, raw_temp_next;
    logic [19:0]        raw_press_reg, raw_press_next;
    logic signed [31:0] last_temp_reg, last_temp_next;
    logic [23:0]        tout_reg, tout_next;
    logic [25:0]        pout_reg, pout_next;
    logic               ok_reg, ok_next;
    logic signed [63:0] rv_reg, rv_next;
    logic signed [63:0] rsq_reg, rsq_next;
    logic signed [63:0] ra_reg, ra_next;
    logic signed [63:0] rb_reg, rb_next;
    logic signed [63:0] rp_reg, rp_next;
    logic signed [63:0] rx_reg, rx_next;
    logic signed [63:0] ry_reg, ry_next;

    logic signed [63:0] t2, t3, p1, p2, p3, p4, p5x2, p6, p7f, p8, p9;
    logic signed [20:0] n21;
    logic signed [63:0] n64;
    logic signed [63:0] lt64;
    logic [63:0]        lt_mag;
    logic [63:0]        lt_q;
    logic [23:0]        tout_stored;
    logic [23:0]        tmag;
    logic [20:0]        pdiff;
    logic signed [63:0] pbase;
    logic signed [63:0] mr;
    logic               is_mul;

    // Trim fields, sign-extended where signed.
    always_comb
    begin
        t2   = {{48{temp_trim[31]}}, temp_trim[31:16]};
        t3   = {{48{temp_trim[47]}}, temp_trim[47:32]};
        p1   = {48'd0, pres_trim_a[15:0]};
        p2   = {{48{pres_trim_a[31]}}, pres_trim_a[31:16]};
        p3   = {{48{pres_trim_a[47]}}, pres_trim_a[47:32]};
        p4   = {{48{pres_trim_a[63]}}, pres_trim_a[63:48]};
        p5x2 = {{47{pres_trim_b[15]}}, pres_trim_b[15:0], 1'b0};
        p6   = {{48{pres_trim_b[31]}}, pres_trim_b[31:16]};
        p7f  = {{48{pres_trim_b[47]}}, pres_trim_b[47:32]} <<< INTERNAL_FRAC_BITS;
        p8   = {{48{pres_trim_b[63]}}, pres_trim_b[63:48]};
        p9   = {{48{pres_trim_c[15]}}, pres_trim_c};
    end

    // Small derived values used by single steps.
    always_comb
    begin
        n21         = $signed({1'b0, raw_temp_reg}) - $signed({1'b0, temp_trim[15:0], 4'd0});
        n64         = {{43{n21[20]}}, n21};
        lt64        = {{32{last_temp_reg[31]}}, last_temp_reg};
        lt_mag      = mag64(lt64);
        lt_q        = (lt_mag + 64'd2048) >> 12;
        tout_stored = lt64[63] ? (24'd0 - lt_q[23:0]) : lt_q[23:0];
        tmag        = div_rsp.quo[35:12] + {23'd0, div_rsp.quo[11]};
        pdiff       = ADC_FULL - {1'b0, raw_press_reg};
        pbase       = {43'd0, pdiff} <<< INTERNAL_FRAC_BITS;
        mr          = mul_rsp.res;
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        is_mul    = 1'b1;
        mul_req.a = UNIT_ONE;
        mul_req.b = UNIT_ONE;
        mul_req.sh = SH_NONE;
        unique case (state_reg)
            ST_T_MUL1: begin mul_req.a = n64;    mul_req.b = t2;                        end
            ST_T_MUL2: begin mul_req.a = n64;    mul_req.b = n64;                       end
            ST_T_MUL3: begin mul_req.a = ry_reg; mul_req.b = t3;                        end
            ST_P_SQ:   begin mul_req.a = rv_reg; mul_req.b = rv_reg; mul_req.sh = SH_FRAC; end
            ST_P_A1:   begin mul_req.a = rsq_reg; mul_req.b = p6; mul_req.sh = SH_15;   end
            ST_P_A2:   begin mul_req.a = rv_reg; mul_req.b = p5x2;                      end
            ST_P_A3:   begin mul_req.a = ra_reg; mul_req.sh = SH_2;                     end
            ST_P_A4:   begin mul_req.a = p4;     mul_req.b = P4_SCALE;                  end
            ST_P_B1:   begin mul_req.a = rsq_reg; mul_req.b = p3; mul_req.sh = SH_19;   end
            ST_P_B2:   begin mul_req.a = rv_reg; mul_req.b = p2;                        end
            ST_P_B3:   begin mul_req.a = rb_reg; mul_req.sh = SH_19;                    end
            ST_P_B4:   begin mul_req.a = rb_reg; mul_req.sh = SH_15;                    end
            ST_P_B5:   begin mul_req.a = rb_reg; mul_req.b = p1;                        end
            ST_P_P1:   begin mul_req.a = ra_reg; mul_req.sh = SH_12;                    end
            ST_P_P2M:  begin mul_req.a = rp_reg; mul_req.b = DIV_MUL;                   end
            ST_P_X1:   begin mul_req.a = rp_reg; mul_req.b = rp_reg; mul_req.sh = SH_FRAC; end
            ST_P_X2:   begin mul_req.a = rx_reg; mul_req.b = p9; mul_req.sh = SH_31;    end
            ST_P_Y:    begin mul_req.a = rp_reg; mul_req.b = p8; mul_req.sh = SH_15;    end
            ST_P_S3:   begin mul_req.a = rx_reg; mul_req.sh = SH_4;                     end
            ST_P_Q:    begin mul_req.a = rp_reg; mul_req.sh = SH_OUT;                   end
            default:   is_mul = 1'b0;
        endcase
        mul_req.start = is_mul && !issued_reg;
    end

    // Divider requests: the temperature scale, or the pressure quotient.
    always_comb
    begin
        div_req.start = ((state_reg == ST_T_DIV) && !issued_reg)
                     || ((state_reg == ST_P_P2M) && mul_rsp.done);
        if (state_reg == ST_T_DIV)
        begin
            div_req.dividend = {64'd0, mag64(rx_reg)};
            div_req.divisor  = TEMP_DEN;
        end
        else
        begin
            div_req.dividend = mul_rsp.prod << INTERNAL_FRAC_BITS;
            div_req.divisor  = mag64(rb_reg);
        end
    end

    // Sequencer: most steps issue one operation and write back when it completes.
    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg | mul_req.start | div_req.start;
        cmd_next       = cmd_reg;
        raw_temp_next  = raw_temp_reg;
        raw_press_next = raw_press_reg;
        last_temp_next = last_temp_reg;
        tout_next      = tout_reg;
        pout_next      = pout_reg;
        ok_next        = ok_reg;
        rv_next        = rv_reg;
        rsq_next       = rsq_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        rp_next        = rp_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                issued_next = 1'b0;
                if (start)
                begin
                    cmd_next       = command;
                    raw_temp_next  = raw_temp;
                    raw_press_next = raw_press;
                    tout_next      = 24'd0;
                    pout_next      = 26'd0;
                    ok_next        = 1'b0;
                    priority if ((command == CMD_BOTH) || (command == CMD_TEMP))
                        state_next = ST_T_MUL1;
                    else if (command == CMD_PRESS)
                    begin
                        tout_next  = tout_stored;
                        state_next = ST_P_V;
                    end
                    else
                        state_next = ST_DONE;
                end
            end
            ST_T_MUL1:
                if (mul_rsp.done) begin rx_next = mr; issued_next = 1'b0; state_next = ST_T_MUL2; end
            ST_T_MUL2:
                if (mul_rsp.done) begin ry_next = mr; issued_next = 1'b0; state_next = ST_T_MUL3; end
            ST_T_MUL3:
                if (mul_rsp.done) begin ry_next = mr; issued_next = 1'b0; state_next = ST_T_ADD; end
            ST_T_ADD:
            begin
                rx_next    = (rx_reg <<< 20) + ry_reg;
                state_next = ST_T_DIV;
            end
            ST_T_DIV:
                if (div_rsp.done)
                begin
                    last_temp_next = rx_reg[63] ? (32'sd0 - $signed(div_rsp.quo_rnd[31:0]))
                                                : $signed(div_rsp.quo_rnd[31:0]);
                    tout_next      = rx_reg[63] ? (24'd0 - tmag) : tmag;
                    issued_next    = 1'b0;
                    state_next     = (cmd_reg == CMD_BOTH) ? ST_P_V : ST_DONE;
                end
            ST_P_V:
            begin
                rv_next    = (((lt64 <<< 2) + lt64) <<< V_SHIFT) - V_OFFSET;
                state_next = ST_P_SQ;
            end
            ST_P_SQ:
                if (mul_rsp.done) begin rsq_next = mr; issued_next = 1'b0; state_next = ST_P_A1; end
            ST_P_A1:
                if (mul_rsp.done) begin ra_next = mr; issued_next = 1'b0; state_next = ST_P_A2; end
            ST_P_A2:
                if (mul_rsp.done)
                begin
                    ra_next = sadd64(ra_reg, mr); issued_next = 1'b0; state_next = ST_P_A3;
                end
            ST_P_A3:
                if (mul_rsp.done) begin ra_next = mr; issued_next = 1'b0; state_next = ST_P_A4; end
            ST_P_A4:
                if (mul_rsp.done)
                begin
                    ra_next = sadd64(ra_reg, mr); issued_next = 1'b0; state_next = ST_P_B1;
                end
            ST_P_B1:
                if (mul_rsp.done) begin rb_next = mr; issued_next = 1'b0; state_next = ST_P_B2; end
            ST_P_B2:
                if (mul_rsp.done)
                begin
                    rb_next = sadd64(rb_reg, mr); issued_next = 1'b0; state_next = ST_P_B3;
                end
            ST_P_B3:
                if (mul_rsp.done) begin rb_next = mr; issued_next = 1'b0; state_next = ST_P_B4; end
            ST_P_B4:
                if (mul_rsp.done)
                begin
                    rb_next = sadd64(ONE_F, mr); issued_next = 1'b0; state_next = ST_P_B5;
                end
            ST_P_B5:
                if (mul_rsp.done)
                begin
                    // A zero divisor ends the item with no pressure.
                    rb_next     = mr;
                    issued_next = 1'b0;
                    state_next  = (mr == 64'sd0) ? ST_DONE : ST_P_P1;
                end
            ST_P_P1:
                if (mul_rsp.done)
                begin
                    rp_next = sadd64(pbase, 64'sd0 - mr); issued_next = 1'b0; state_next = ST_P_P2M;
                end
            ST_P_P2M:
                if (mul_rsp.done) state_next = ST_P_P2D;
            ST_P_P2D:
                if (div_rsp.done)
                begin
                    rp_next     = signsat(rp_reg[63] ^ rb_reg[63], div_rsp.quo_rnd);
                    issued_next = 1'b0;
                    state_next  = ST_P_X1;
                end
            ST_P_X1:
                if (mul_rsp.done) begin rx_next = mr; issued_next = 1'b0; state_next = ST_P_X2; end
            ST_P_X2:
                if (mul_rsp.done) begin rx_next = mr; issued_next = 1'b0; state_next = ST_P_Y; end
            ST_P_Y:
                if (mul_rsp.done) begin ry_next = mr; issued_next = 1'b0; state_next = ST_P_S1; end
            ST_P_S1:
            begin
                rx_next    = sadd64(rx_reg, ry_reg);
                state_next = ST_P_S2;
            end
            ST_P_S2:
            begin
                rx_next    = sadd64(rx_reg, p7f);
                state_next = ST_P_S3;
            end
            ST_P_S3:
                if (mul_rsp.done)
                begin
                    rp_next = sadd64(rp_reg, mr); issued_next = 1'b0; state_next = ST_P_Q;
                end
            ST_P_Q:
                if (mul_rsp.done)
                begin
                    // Clamp to the output range.
                    priority if (mr[63])
                        pout_next = 26'd0;
                    else if (mr > PRESS_MAX)
                        pout_next = PRESS_MAX[25:0];
                    else
                        pout_next = mr[25:0];
                    ok_next     = 1'b1;
                    issued_next = 1'b0;
                    state_next  = ST_DONE;
                end
            ST_DONE:
            begin
                issued_next = 1'b0;
                if (take)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state and the stored temperature.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            last_temp_reg <= 32'sd0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            last_temp_reg <= last_temp_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        raw_temp_reg  <= raw_temp_next;
        raw_press_reg <= raw_press_next;
        tout_reg      <= tout_next;
        pout_reg      <= pout_next;
        ok_reg        <= ok_next;
        rv_reg        <= rv_next;
        rsq_reg       <= rsq_next;
        ra_reg        <= ra_next;
        rb_reg        <= rb_next;
        rp_reg        <= rp_next;
        rx_reg        <= rx_next;
        ry_reg        <= ry_next;
    end

    assign stat.ready = (state_reg == ST_IDLE);
    assign stat.done  = (state_reg == ST_DONE);
    assign temp_res   = tout_reg;
    assign press_res  = pout_reg;
    assign ok_res     = ok_reg;

endmodule

// ===== hw/rtl/baro_temp_compensation.sv =====
`timescale 1ns / 1ps
// Commands: temperature only, pressure from the stored temperature, or both; an unused
// command goes straight to the finished state with an empty word. Output stalls hold a finished word back.
// One word is worked at a time; the next is taken in the cycle after the result moves out.
// The shared 32x32 multiplier and the one-bit-a-cycle 128-step divider do the arithmetic.
// Reset clears the trims and the stored temperature.

module baro_temp_compensation
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [19:0]        raw_temp,
    input  logic [19:0]        raw_press,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] temp_out,
    output logic [25:0]        press_out,
    output logic               press_valid,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import btc_pkg::*;

    logic [47:0]  temp_trim_reg;
    logic [63:0]  pres_a_reg;
    logic [63:0]  pres_b_reg;
    logic [15:0]  pres_c_reg;
    logic         out_valid_reg;
    logic [23:0]  temp_out_reg;
    logic [25:0]  press_out_reg;
    logic         press_valid_reg;

    core_stat_t   core_stat;
    mul_req_t     mul_req;
    mul_rsp_t     mul_rsp;
    div_req_t     div_req;
    div_rsp_t     div_rsp;
    logic [23:0]  temp_res;
    logic [25:0]  press_res;
    logic         ok_res;
    logic         accept;
    logic         take;

    assign cfg_ready = 1'b1;
    assign in_stall  = !core_stat.ready;
    assign accept    = in_valid && !in_stall;
    assign take      = core_stat.done && (!out_valid_reg || !out_stall);

    // Trim registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_trim_reg <= 48'd0;
            pres_a_reg    <= 64'd0;
            pres_b_reg    <= 64'd0;
            pres_c_reg    <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TEMP_TRIM: temp_trim_reg <= cfg_data[47:0];
                CFG_PRES_A:    pres_a_reg    <= cfg_data;
                CFG_PRES_B:    pres_b_reg    <= cfg_data;
                CFG_PRES_C:    pres_c_reg    <= cfg_data[15:0];
            endcase
        end
    end

    // Output word register; the sequencer may start the next word while this one waits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            temp_out_reg    <= temp_res;
            press_out_reg   <= press_res;
            press_valid_reg <= ok_res;
        end
    end

    btc_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    btc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    btc_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .command     (command),
        .raw_temp    (raw_temp),
        .raw_press   (raw_press),
        .take        (take),
        .temp_trim   (temp_trim_reg),
        .pres_trim_a (pres_a_reg),
        .pres_trim_b (pres_b_reg),
        .pres_trim_c (pres_c_reg),
        .stat        (core_stat),
        .temp_res    (temp_res),
        .press_res   (press_res),
        .ok_res      (ok_res),
        .mul_req     (mul_req),
        .mul_rsp     (mul_rsp),
        .div_req     (div_req),
        .div_rsp     (div_rsp)
    );

    assign out_valid   = out_valid_reg;
    assign temp_out    = $signed(temp_out_reg);
    assign press_out   = press_out_reg;
    assign press_valid = press_valid_reg;

    // A word without pressure carries a zero pressure field.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !press_valid |-> press_out == 26'd0)
        else $error("pressure field not zero on a word without pressure");

    // An accepted word keeps the input stalled on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input taken again while a word is in progress");

    // A finished result moves into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid && !core_stat.done)
        else $error("finished result not handed to the output");

    // The shared units are never started together.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> !div_req.start)
        else $error("multiplier and divider started in the same cycle");

endmodule
